// ===== rtl/core/srr_pkg.sv =====
// Shared types and constants of the selective-repeat receiver.
package srr_pkg;

  localparam int SEQ_SPACE_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int SEQ_W     = 3;
  localparam int WIN_W     = 4;
  localparam int WORD_W    = 64;
  localparam int MAX_DELIVER = 8;
  localparam int CNT_W     = $clog2(MAX_DELIVER + 1);

  localparam logic [WIN_W-1:0] WIN_SIZE_RST = WIN_W'(4);

  typedef enum logic {
    KIND_ACK = 1'b0,
    KIND_DLV = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_DLV
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch arriving item
    logic ack;      // emit acknowledgement, buffer payload if in window
    logic dlv;      // emit one in-order delivery
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic ack_more;  // a delivery follows the acknowledgement
    logic dlv_more;  // another delivery follows this one
  } sts_t;

endpackage

// ===== rtl/core/srr_ctrl.sv =====
// Sequencer of the selective-repeat receiver.
module srr_ctrl import srr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic checksum_good_i,
  output logic in_stall_o,
  output logic cfg_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && checksum_good_i) begin
          state_d = ST_ACK;
        end
      end
      ST_ACK: begin
        if (sts_i.out_free) begin
          state_d = sts_i.ack_more ? ST_DLV : ST_IDLE;
        end
      end
      ST_DLV: begin
        if (sts_i.out_free) begin
          state_d = sts_i.dlv_more ? ST_DLV : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_ACK:  cmd_o.ack = sts_i.out_free;
      ST_DLV:  cmd_o.dlv = sts_i.out_free;
      default: cmd_o     = '0;
    endcase
  end

endmodule

// ===== rtl/core/srr_dpath.sv =====
// Window state, payload buffer and output register of the receiver.
module srr_dpath import srr_pkg::*; #(
  parameter int SeqSpace    = SEQ_SPACE_DEF,
  parameter int PayloadBits = PAYLOAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [SEQ_W-1:0]  seq_number_i,
  input  logic [WORD_W-1:0] payload_word_i,
  input  logic              cfg_we_i,
  input  logic [WIN_W-1:0]  cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              result_kind_o,
  output logic [SEQ_W-1:0]  ack_number_o,
  output logic [WORD_W-1:0] delivered_payload_o,
  output logic              last_of_run_o
);

  localparam int BW = (SeqSpace > 1) ? $clog2(SeqSpace) : 1;

  logic [SEQ_W-1:0]       seq_q;
  logic [PayloadBits-1:0] pay_q;
  logic [BW-1:0]          base_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [WIN_W-1:0]       win_q;
  logic [SeqSpace-1:0]    mark_q;
  logic [PayloadBits-1:0] mem_q [SeqSpace];
  logic [PayloadBits-1:0] rd_q;

  logic                   out_valid_q;
  logic                   kind_q;
  logic [SEQ_W-1:0]       num_q;
  logic [WORD_W-1:0]      data_q;
  logic                   last_q;

  logic [BW+SEQ_W-1:0]    seq_wide;
  logic [BW-1:0]          seq_idx;
  logic                   seq_ok;
  logic [BW:0]            off_sum;
  logic [BW-1:0]          offset;
  logic                   in_win;
  logic [BW-1:0]          base_nxt;
  logic [BW+SEQ_W-1:0]    base_wide;
  logic                   wr_en;
  logic [BW-1:0]          rd_addr;

  // window test: offset of seq from base, modulo the sequence space
  assign seq_wide = (BW+SEQ_W)'(seq_q);
  assign seq_idx  = seq_wide[BW-1:0];
  assign seq_ok   = 32'(seq_q) < 32'(SeqSpace);
  assign off_sum  = {1'b0, seq_idx} + (BW+1)'(SeqSpace) - {1'b0, base_q};
  assign offset   = (32'(off_sum) >= 32'(SeqSpace)) ?
                    BW'(off_sum - (BW+1)'(SeqSpace)) : off_sum[BW-1:0];
  assign in_win   = seq_ok && (32'(offset) < 32'(win_q));

  assign base_nxt  = (32'(base_q) == 32'(SeqSpace - 1)) ? '0 : base_q + BW'(1);
  assign base_wide = (BW+SEQ_W)'(base_q);

  assign wr_en   = cmd_i.ack && in_win;
  assign rd_addr = cmd_i.ack ? base_q : base_nxt;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.ack_more = in_win && ((seq_idx == base_q) || mark_q[base_q]);
  assign sts_o.dlv_more = ((32'(cnt_q) + 32'd1) < 32'(MAX_DELIVER)) && mark_q[base_nxt];

  // item and window registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seq_q <= seq_number_i;
      pay_q <= payload_word_i[PayloadBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cnt_q  <= '0;
      win_q  <= WIN_SIZE_RST;
      mark_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end
      if (wr_en) begin
        mark_q[seq_idx] <= 1'b1;
      end
      if (cmd_i.dlv) begin
        mark_q[base_q] <= 1'b0;
        base_q         <= base_nxt;
        cnt_q          <= cnt_q + CNT_W'(1);
      end
    end
  end

  // payload buffer, registered read with write-through for the same slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[seq_idx] <= pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ack || cmd_i.dlv) begin
      if (wr_en && (seq_idx == rd_addr)) begin
        rd_q <= pay_q;
      end else begin
        rd_q <= mem_q[rd_addr];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ack || cmd_i.dlv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ack) begin
      kind_q <= KIND_ACK;
      num_q  <= seq_q;
      data_q <= '0;
      last_q <= !sts_o.ack_more;
    end else if (cmd_i.dlv) begin
      kind_q <= KIND_DLV;
      num_q  <= base_wide[SEQ_W-1:0];
      data_q <= WORD_W'(rd_q);
      last_q <= !sts_o.dlv_more;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = kind_q;
  assign ack_number_o        = num_q;
  assign delivered_payload_o = data_q;
  assign last_of_run_o       = last_q;

endmodule

// ===== rtl/core/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver: sequencer plus datapath.
//
// Usage notes:
// - Input channel (in_valid_i / in_stall_o): one packet per item, with its
//   sequence number, checksum flag and payload word. The item is taken on a
//   clock edge where in_valid_i is high and in_stall_o is low.
// - Output channel (out_valid_o / out_stall_i): per good packet first an
//   acknowledgement (result_kind_o = 0), then any in-order deliveries
//   (result_kind_o = 1). last_of_run_o marks the final result of a packet.
//   A corrupt packet gives nothing.
// - Config channel (cfg_valid_i / cfg_ready_o): writes window_size. Ready
//   only while idle between packets.
// - Timing: the taken item is latched and the sequencer enters ACK; the
//   ack goes to the output register, then each delivery from DLV. A good
//   packet stalls the input through its last result (up to 8 deliveries);
//   a corrupt one is taken with no stall. One delivery per cycle while the
//   output is free is set by the single read port of the payload buffer.
// - Output stall: results sit in the output register; the sequencer pauses
//   until the register is free, nothing is lost.
// - Reset: base goes to zero, all received marks clear at once (flip-flops),
//   window_size returns to 4. No clearing pass is needed.
module selective_repeat_receiver import srr_pkg::*; #(
  parameter int SeqSpace    = SEQ_SPACE_DEF,
  parameter int PayloadBits = PAYLOAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SEQ_W-1:0]  seq_number_i,
  input  logic              checksum_good_i,
  input  logic [WORD_W-1:0] payload_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [SEQ_W-1:0]  ack_number_o,
  output logic [WORD_W-1:0] delivered_payload_o,
  output logic              last_of_run_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WIN_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  srr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .checksum_good_i (checksum_good_i),
    .in_stall_o      (in_stall_o),
    .cfg_ready_o     (cfg_ready_o),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  srr_dpath #(
    .SeqSpace    (SeqSpace),
    .PayloadBits (PayloadBits)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .seq_number_i        (seq_number_i),
    .payload_word_i      (payload_word_i),
    .cfg_we_i            (cfg_we),
    .cfg_data_i          (cfg_data_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .result_kind_o       (result_kind_o),
    .ack_number_o        (ack_number_o),
    .delivered_payload_o (delivered_payload_o),
    .last_of_run_o       (last_of_run_o)
  );

endmodule

// ===== verif/srr_result_checker.sv =====
// Scoreboard for the selective-repeat receiver: predicts acks and deliveries, compares results.
module srr_result_checker import srr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [SEQ_W-1:0]  seq_number_i,
  input  logic              checksum_good_i,
  input  logic [WORD_W-1:0] payload_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              result_kind_i,
  input  logic [SEQ_W-1:0]  ack_number_i,
  input  logic [WORD_W-1:0] delivered_payload_i,
  input  logic              last_of_run_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [WIN_W-1:0]  cfg_data_i,
  output int                pending_o,
  output int                fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  num;
    logic [WORD_W-1:0] payload;
    logic              last;
  } rx_result_t;

  rx_result_t        expected_results[$];
  logic [SEQ_W-1:0]  rx_base;
  logic              rx_marked [SEQ_SPACE_DEF];
  logic [WORD_W-1:0] rx_buffer [SEQ_SPACE_DEF];
  logic [WIN_W-1:0]  win_size;
  int                fails = 0;

  function automatic bit in_rx_window(logic [SEQ_W-1:0] seq);
    int offset;
    offset = (int'(seq) + SEQ_SPACE_DEF - int'(rx_base)) % SEQ_SPACE_DEF;
    return offset < int'(win_size);
  endfunction

  // One packet: ack first, then the in-order run starting at the base.
  // The last result is held back so its end-of-run flag can be set.
  task automatic predict_packet(logic [SEQ_W-1:0] seq, logic good, logic [WORD_W-1:0] word);
    rx_result_t held;
    int         delivered;
    if (!good) return;
    held = '{kind: KIND_ACK, num: seq, payload: '0, last: 1'b0};
    if (in_rx_window(seq)) begin
      rx_buffer[seq] = word;
      rx_marked[seq] = 1'b1;
      delivered = 0;
      while (delivered < MAX_DELIVER && rx_marked[rx_base]) begin
        expected_results.push_back(held);
        held = '{kind: KIND_DLV, num: rx_base, payload: rx_buffer[rx_base], last: 1'b0};
        rx_marked[rx_base] = 1'b0;
        rx_base = SEQ_W'((int'(rx_base) + 1) % SEQ_SPACE_DEF);
        delivered++;
      end
    end
    held.last = 1'b1;
    expected_results.push_back(held);
  endtask

  function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
    if (got !== want) begin
      if (fails < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endfunction

  task automatic check_result();
    rx_result_t want;
    if (expected_results.size() == 0) begin
      if (fails < MAX_REPORTS)
        $display("%0t: stray result: expected none, got kind %0d num %0d payload %h last %0b",
                 $time, result_kind_i, ack_number_i, delivered_payload_i, last_of_run_i);
      fails++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", WORD_W'(want.kind), WORD_W'(result_kind_i));
    compare_field("ack_number", WORD_W'(want.num), WORD_W'(ack_number_i));
    compare_field("delivered_payload", want.payload, delivered_payload_i);
    compare_field("last_of_run", WORD_W'(want.last), WORD_W'(last_of_run_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_base  = '0;
      win_size = WIN_SIZE_RST;
      for (int i = 0; i < SEQ_SPACE_DEF; i++) rx_marked[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) win_size = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i)
        predict_packet(seq_number_i, checksum_good_i, payload_word_i);
    end
    pending_o    <= expected_results.size();
    fail_count_o <= fails;
  end

endmodule

// ===== verif/selective_repeat_receiver_tb.sv =====
// Testbench top for the selective-repeat receiver: stimulus, stalls, watchdog and verdict.
module selective_repeat_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  localparam int IDLE_PCT       = 18;    // per-cycle idle/stall chance on each side
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 4;     // a dropped item may still be in flight
  localparam int DRAIN_CYCLES   = 30;    // tail after the last expected result
  localparam int PHASE_GOOD     = 24;    // good packets per random phase, 8 phases

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SEQ_W-1:0]  seq_number_i;
  logic              checksum_good_i;
  logic [WORD_W-1:0] payload_word_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              result_kind_o;
  logic [SEQ_W-1:0]  ack_number_o;
  logic [WORD_W-1:0] delivered_payload_o;
  logic              last_of_run_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [WIN_W-1:0]  cfg_data_i;

  int checker_pending;
  int checker_fails;

  // Stimulus bookkeeping
  bit               calm = 1'b0;  // set: neither side idles
  logic [SEQ_W-1:0] sender_base;  // where the sender thinks the receive window starts
  int good_sent     = 0;
  int corrupt_sent  = 0;
  int acks_seen     = 0;
  int deliveries_seen = 0;
  int window_writes = 0;
  int quiet_cycles  = 0;

  selective_repeat_receiver DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .seq_number_i        (seq_number_i),
    .checksum_good_i     (checksum_good_i),
    .payload_word_i      (payload_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .ack_number_o        (ack_number_o),
    .delivered_payload_o (delivered_payload_o),
    .last_of_run_o       (last_of_run_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  srr_result_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .seq_number_i        (seq_number_i),
    .checksum_good_i     (checksum_good_i),
    .payload_word_i      (payload_word_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_i       (result_kind_o),
    .ack_number_i        (ack_number_o),
    .delivered_payload_i (delivered_payload_o),
    .last_of_run_i       (last_of_run_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .pending_o           (checker_pending),
    .fail_count_o        (checker_fails)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side backpressure, random except in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: any handshake on any channel counts as progress.
  // Also tallies acks and deliveries for the closing summary.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (result_kind_o == KIND_DLV) deliveries_seen++;
      else acks_seen++;
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Present one packet and hold it until taken. A random gap may come first;
  // valid is either lowered for the gap or kept high, never both in one step.
  task automatic send_packet(logic [SEQ_W-1:0] seq, logic good, logic [WORD_W-1:0] word);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid_i      <= 1'b1;
    seq_number_i    <= seq;
    checksum_good_i <= good;
    payload_word_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    if (good) good_sent++;
    else corrupt_sent++;
  endtask

  // The checker's pending count is registered; once the loop has waited for an
  // edge, it already reflects the packet taken at the current one.
  task automatic wait_drained();
    do @(posedge clk_i); while (checker_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Window size only changes with the receiver idle
  task automatic write_window(logic [WIN_W-1:0] size);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_writes++;
  endtask

  // One sender window: every number from sender_base in shuffled order, with
  // corrupt copies that get resent, duplicate retransmits and noise packets
  // (corrupt ones, or stale numbers that fall outside the window). The block
  // ends once every number got through, so the receiver base stays in step.
  task automatic run_block(int span);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] tmp;
    bit               got [SEQ_SPACE_DEF];
    int               landed;
    int               j;
    landed = 0;
    for (int i = 0; i < SEQ_SPACE_DEF; i++) got[i] = 1'b0;
    for (int i = 0; i < span; i++) order.push_back(SEQ_W'(int'(sender_base) + i));
    for (int i = span - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    while (landed < span) begin
      seq = order.pop_front();
      if ($urandom_range(0, 99) < 12) begin
        if (span < SEQ_SPACE_DEF && $urandom_range(0, 1) == 1)
          send_packet(SEQ_W'(int'(sender_base) + $urandom_range(span, SEQ_SPACE_DEF - 1)),
                      1'b1, rand_word());
        else
          send_packet(SEQ_W'($urandom_range(0, SEQ_SPACE_DEF - 1)), 1'b0, rand_word());
      end
      if ($urandom_range(0, 99) < 15) begin
        send_packet(seq, 1'b0, rand_word());
        order.push_back(seq);
      end else begin
        send_packet(seq, 1'b1, rand_word());
        if (!got[seq]) begin
          got[seq] = 1'b1;
          landed++;
        end
        if ($urandom_range(0, 99) < 8) order.push_back(seq);
      end
    end
    sender_base = SEQ_W'(int'(sender_base) + span);
  endtask

  initial begin
    int phase_sizes[8];
    int ws;
    int span;
    int target;
    phase_sizes = '{8, 1, 15, 3, -1, 8, 2, -1};  // -1: pick at random

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    seq_number_i    = '0;
    checksum_good_i = 1'b0;
    payload_word_i  = '0;
    out_stall_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset window of 4 at base 0
    send_packet(3'd0, 1'b1, '1);                     // in order: ack plus delivery
    send_packet(3'd0, 1'b0, '1);                     // corrupt: dropped silently
    send_packet(3'd2, 1'b1, '0);                     // buffered ahead of the gap
    send_packet(3'd2, 1'b1, 64'h5555_5555_5555_5555); // same slot again: overwritten
    send_packet(3'd4, 1'b1, rand_word());            // last slot inside the window
    send_packet(3'd5, 1'b1, rand_word());            // one past the window: ack only
    send_packet(3'd7, 1'b1, rand_word());            // stale number: ack only
    send_packet(3'd3, 1'b1, rand_word());
    send_packet(3'd1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA); // fills the gap: four deliveries
    send_packet(3'd6, 1'b0, rand_word());

    // Smallest window, base now 5
    write_window(4'd1);
    send_packet(3'd6, 1'b1, rand_word());            // just outside
    send_packet(3'd5, 1'b1, rand_word());

    // Window above the sequence space: every number is in, base 6.
    // Offset 7 goes first, the base last, so the final packet drains all eight.
    write_window(4'd15);
    send_packet(3'd5, 1'b1, rand_word());
    send_packet(3'd7, 1'b1, rand_word());
    send_packet(3'd0, 1'b1, rand_word());
    send_packet(3'd1, 1'b1, rand_word());
    send_packet(3'd2, 1'b1, rand_word());
    send_packet(3'd3, 1'b1, rand_word());
    send_packet(3'd4, 1'b1, rand_word());
    send_packet(3'd6, 1'b1, rand_word());

    // Empty window: nothing is ever buffered, even the base
    write_window(4'd0);
    send_packet(3'd6, 1'b1, rand_word());
    send_packet(3'd7, 1'b1, rand_word());
    sender_base = 3'd6;

    // Random part: phases of well-formed sender windows, one window size each
    for (int p = 0; p < 8; p++) begin
      ws = (phase_sizes[p] < 0) ? $urandom_range(2, 7) : phase_sizes[p];
      write_window(WIN_W'(ws));
      calm   = (p == 2);                             // long stretch with no idling
      span   = (ws >= SEQ_SPACE_DEF) ? SEQ_SPACE_DEF : ws;
      target = good_sent + PHASE_GOOD;
      while (good_sent < target) run_block(span);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d good and %0d corrupt packets; %0d acks and %0d deliveries checked,",
             good_sent, corrupt_sent, acks_seen, deliveries_seen);
    $display("with %0d window size writes spanning 0 to 15.", window_writes);
    if (checker_fails == 0 && checker_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", checker_fails, checker_pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/srr_pkg.sv
rtl/core/srr_ctrl.sv
rtl/core/srr_dpath.sv
rtl/core/selective_repeat_receiver.sv
verif/srr_result_checker.sv
verif/selective_repeat_receiver_tb.sv
